// File: src/pba_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pba_pkg
// Shared types and constants of the paged bump allocator.
// ----------------------------------------------------------------------------
package pba_pkg;

  localparam int PAGE_BYTES_DEF = 4096;
  localparam int MAX_PAGES_DEF  = 16;

  localparam int REQ_W    = 16;
  localparam int STATUS_W = 2;
  localparam int PAGE_W   = 4;
  localparam int OFFSET_W = 13;
  localparam int POOL_W   = 17;
  localparam int SUM_W    = 17;

  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 40;

  localparam logic KIND_ALLOC   = 1'b0;
  localparam logic KIND_RELEASE = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_TOO_BIG  = 2'd1,
    ST_NO_PAGES = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_CHECK,
    S_APPEND,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic             fits;
    logic [SUM_W-1:0] sum;
  } fit_res_t;

endpackage

// File: src/pba_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pba_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: src/pba_fit_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pba_fit_unit
// Shared adder and compare: does a request fit on top of a page fill.
// ----------------------------------------------------------------------------
module pba_fit_unit
  import pba_pkg::*;
#(
  parameter int PAGE_BYTES = PAGE_BYTES_DEF,
  parameter int FILL_W     = 13
) (
  input  logic [FILL_W-1:0] fill,
  input  logic [REQ_W-1:0]  req,
  output fit_res_t          res
);

  localparam int TOT_W = SUM_W + 1;

  logic [TOT_W-1:0] total;

  assign total    = TOT_W'(fill) + TOT_W'(req);
  assign res.fits = (total <= TOT_W'(PAGE_BYTES));
  assign res.sum  = total[SUM_W-1:0];

endmodule

// File: src/paged_bump_allocator_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// paged_bump_allocator_core
// Paged bump allocator with first-fit page choice over a page fill RAM.
// ----------------------------------------------------------------------------
// One beat in, one beat out. A release or an oversized request goes from accept
// straight to the emit state, which loads the output register. An allocation reads
// the fills of the pages in use one after another through the fill RAM and the
// shared fit unit, each page in a read state (registered RAM read) and then a
// check state (compare), plus an append state when none fits and the emit state
// to load the result. in_tready is high only while the sequencer is idle; the
// output register holds a result until it is taken. Release resets the page
// count only; pages beyond the count are rewritten before they are read again.
// ----------------------------------------------------------------------------
module paged_bump_allocator_core
  import pba_pkg::*;
#(
  parameter int PAGE_BYTES = PAGE_BYTES_DEF,
  parameter int MAX_PAGES  = MAX_PAGES_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // [15:0] request_bytes
  input  logic                   in_tuser,   // [0] kind
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata   // [1:0] status, [5:2] page_number,
                                             // [18:6] byte_offset,
                                             // [35:19] pool_bytes, [39:36] zero
);

  localparam int FILL_W  = $clog2(PAGE_BYTES + 1);
  localparam int IDX_W   = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
  localparam int CNT_W   = $clog2(MAX_PAGES + 1);
  localparam int PROD_W  = CNT_W + POOL_W;
  localparam int PAD_W   = OUT_TDATA_W - STATUS_W - PAGE_W - OFFSET_W - POOL_W;

  state_t                 state_r, state_nxt;
  logic [REQ_W-1:0]       req_r, req_nxt;
  logic [CNT_W-1:0]       pages_r, pages_nxt;
  logic [CNT_W-1:0]       idx_r, idx_nxt;
  status_t                res_status_r, res_status_nxt;
  logic [CNT_W-1:0]       res_page_r, res_page_nxt;
  logic [FILL_W-1:0]      res_offset_r, res_offset_nxt;
  logic                   out_tvalid_r, out_tvalid_nxt;
  logic [OUT_TDATA_W-1:0] out_tdata_r, out_tdata_nxt;

  logic                   ram_we;
  logic [IDX_W-1:0]       ram_waddr;
  logic [FILL_W-1:0]      ram_wdata;
  logic [FILL_W-1:0]      ram_rdata;
  fit_res_t               fit;
  logic [PROD_W-1:0]      pool_full;
  logic                   slot_free;
  logic [CNT_W-1:0]       idx_inc;

  pba_ram #(
    .WIDTH (FILL_W),
    .DEPTH (MAX_PAGES)
  ) u_fill_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (idx_r[IDX_W-1:0]),
    .rdata (ram_rdata)
  );

  pba_fit_unit #(
    .PAGE_BYTES (PAGE_BYTES),
    .FILL_W     (FILL_W)
  ) u_fit (
    .fill (ram_rdata),
    .req  (req_r),
    .res  (fit)
  );

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign slot_free  = !out_tvalid_r || out_tready;
  assign pool_full  = PROD_W'(pages_r) * PROD_W'(PAGE_BYTES);
  assign idx_inc    = idx_r + CNT_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      pages_r      <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      pages_r      <= pages_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r        <= req_nxt;
    idx_r        <= idx_nxt;
    res_status_r <= res_status_nxt;
    res_page_r   <= res_page_nxt;
    res_offset_r <= res_offset_nxt;
    out_tdata_r  <= out_tdata_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    req_nxt        = req_r;
    pages_nxt      = pages_r;
    idx_nxt        = idx_r;
    res_status_nxt = res_status_r;
    res_page_nxt   = res_page_r;
    res_offset_nxt = res_offset_r;
    out_tvalid_nxt = out_tvalid_r;
    out_tdata_nxt  = out_tdata_r;
    ram_we         = 1'b0;
    ram_waddr      = idx_r[IDX_W-1:0];
    ram_wdata      = fit.sum[FILL_W-1:0];

    if (out_tvalid_r && out_tready) begin
      out_tvalid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          req_nxt        = in_tdata[REQ_W-1:0];
          idx_nxt        = '0;
          res_status_nxt = ST_OK;
          res_page_nxt   = '0;
          res_offset_nxt = '0;
          if (in_tuser == KIND_RELEASE) begin
            pages_nxt = '0;
            state_nxt = S_EMIT;
          end else if ({1'b0, in_tdata[REQ_W-1:0]} > (REQ_W + 1)'(PAGE_BYTES)) begin
            res_status_nxt = ST_TOO_BIG;
            state_nxt      = S_EMIT;
          end else if (pages_r == '0) begin
            state_nxt = S_APPEND;
          end else begin
            state_nxt = S_READ;
          end
        end
      end
      S_READ: begin
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        if (fit.fits) begin
          ram_we         = 1'b1;
          res_page_nxt   = idx_r;
          res_offset_nxt = ram_rdata;
          state_nxt      = S_EMIT;
        end else begin
          idx_nxt   = idx_inc;
          state_nxt = (idx_inc == pages_r) ? S_APPEND : S_READ;
        end
      end
      S_APPEND: begin
        if (pages_r >= CNT_W'(MAX_PAGES)) begin
          res_status_nxt = ST_NO_PAGES;
        end else begin
          ram_we         = 1'b1;
          ram_waddr      = pages_r[IDX_W-1:0];
          ram_wdata      = FILL_W'({1'b0, req_r});
          res_page_nxt   = pages_r;
          res_offset_nxt = '0;
          pages_nxt      = pages_r + CNT_W'(1);
        end
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (slot_free) begin
          out_tvalid_nxt = 1'b1;
          out_tdata_nxt  = {PAD_W'(0),
                            pool_full[POOL_W-1:0],
                            OFFSET_W'(res_offset_r),
                            PAGE_W'(res_page_r),
                            res_status_r};
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule
